// ----- hw/rtl/abs_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the alternating-bit sender.
// Used by abs_ack_chk and alternating_bit_sender; depends on nothing else.
package abs_pkg;

    // Field widths of the input and output transactions
    localparam int ByteW     = 8;
    localparam int AckSeqW   = 20;
    localparam int AckNumW   = 20;
    localparam int AckSumW   = 22;
    localparam int ChkW      = 13;
    localparam int ReqW      = 2;
    localparam int KindW     = 3;
    localparam int InTdataW  = 72;
    localparam int OutTdataW = 24;

    // Bit-serial ack check: seq + num + sum fits in 23 bits
    localparam int ChkBits = 23;
    localparam int ChkCntW = 5;

    typedef enum logic [ReqW-1:0] {
        REQ_MSG     = 2'd0,
        REQ_ACK     = 2'd1,
        REQ_TIMEOUT = 2'd2
    } req_t;

    typedef enum logic [KindW-1:0] {
        KIND_PKT     = 3'd0,
        KIND_ACK_OK  = 3'd1,
        KIND_CORRUPT = 3'd2,
        KIND_DUP     = 3'd3,
        KIND_DROP    = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_SEND,
        ST_CHECK,
        ST_REPORT
    } state_t;

    // Status from the serial ack checker
    typedef struct packed {
        logic done;
        logic corrupt;
    } ack_chk_status_t;

endpackage

// ----- hw/rtl/abs_ack_chk.sv -----
`timescale 1ns / 1ps
// Bit-serial ack checker: adds seq, num and byte sum one bit per cycle
// and compares against the received checksum. Depends on abs_pkg.
module abs_ack_chk (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [abs_pkg::AckSeqW-1:0]     ack_seq,
    input  logic [abs_pkg::AckNumW-1:0]     ack_num,
    input  logic [abs_pkg::AckSumW-1:0]     ack_sum,
    input  logic [abs_pkg::AckSumW-1:0]     ack_check,
    output abs_pkg::ack_chk_status_t        status
);
    import abs_pkg::*;

    logic [AckSeqW-1:0] seq_sr_reg, seq_sr_next;
    logic [AckNumW-1:0] num_sr_reg, num_sr_next;
    logic [AckSumW-1:0] sum_sr_reg, sum_sr_next;
    logic [AckSumW-1:0] ref_sr_reg, ref_sr_next;
    logic [1:0]         carry_reg, carry_next;
    logic               miss_reg, miss_next;
    logic               busy_reg, busy_next;
    logic [ChkCntW-1:0] bit_reg, bit_next;
    logic [2:0]         bit_total;
    logic               miss_now;
    logic               done_now;

    // One bit of the three-way sum plus carry
    assign bit_total = {2'b00, seq_sr_reg[0]} + {2'b00, num_sr_reg[0]}
                     + {2'b00, sum_sr_reg[0]} + {1'b0, carry_reg};
    assign miss_now  = miss_reg | (bit_total[0] != ref_sr_reg[0]);
    assign done_now  = busy_reg && (bit_reg == ChkCntW'(ChkBits - 1));

    assign status.done    = done_now;
    assign status.corrupt = miss_now;

    // Load on start, otherwise shift one bit per cycle while busy
    always_comb
    begin
        seq_sr_next = seq_sr_reg;
        num_sr_next = num_sr_reg;
        sum_sr_next = sum_sr_reg;
        ref_sr_next = ref_sr_reg;
        carry_next  = carry_reg;
        miss_next   = miss_reg;
        busy_next   = busy_reg;
        bit_next    = bit_reg;
        if (start)
        begin
            seq_sr_next = ack_seq;
            num_sr_next = ack_num;
            sum_sr_next = ack_sum;
            ref_sr_next = ack_check;
            carry_next  = 2'b00;
            miss_next   = 1'b0;
            busy_next   = 1'b1;
            bit_next    = '0;
        end
        else if (busy_reg)
        begin
            seq_sr_next = {1'b0, seq_sr_reg[AckSeqW-1:1]};
            num_sr_next = {1'b0, num_sr_reg[AckNumW-1:1]};
            sum_sr_next = {1'b0, sum_sr_reg[AckSumW-1:1]};
            ref_sr_next = {1'b0, ref_sr_reg[AckSumW-1:1]};
            carry_next  = bit_total[2:1];
            miss_next   = miss_now;
            bit_next    = bit_reg + ChkCntW'(1);
            if (done_now)
            begin
                busy_next = 1'b0;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            bit_reg   <= '0;
            carry_reg <= 2'b00;
            miss_reg  <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            bit_reg   <= bit_next;
            carry_reg <= carry_next;
            miss_reg  <= miss_next;
        end
    end

    // Operand shift registers
    always_ff @(posedge clk)
    begin
        seq_sr_reg <= seq_sr_next;
        num_sr_reg <= num_sr_next;
        sum_sr_reg <= sum_sr_next;
        ref_sr_reg <= ref_sr_next;
    end

endmodule

// ----- hw/rtl/alternating_bit_sender.sv -----
`timescale 1ns / 1ps
// Alternating-bit sender. Message and ack bytes are accepted only while idle.
// A message end is followed by zero fill of each unwritten slot of the byte shift
// register, then PAYLOAD_BYTES send transactions; a replay sends PAYLOAD_BYTES directly.
// An ack end runs the bit-serial checker, then a report transaction.
// rst_n clears all control state asynchronously; packet bytes are not reset.
// Depends on abs_pkg and abs_ack_chk.
module alternating_bit_sender #(
    parameter int PAYLOAD_BYTES = 20
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // data_byte[7:0], ack_seq_field[27:8], ack_num_field[47:28],
    // ack_check_field[69:48], zero fill[71:70]
    input  logic [abs_pkg::InTdataW-1:0]      s_axis_tdata,
    input  logic                              s_axis_tlast,
    // req_type[1:0]
    input  logic [abs_pkg::ReqW-1:0]          s_axis_tuser,
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // out_seq[0], out_checksum[13:1], out_byte[21:14], timer_start[22],
    // timer_stop[23]
    output logic [abs_pkg::OutTdataW-1:0]     m_axis_tdata,
    output logic                              m_axis_tlast,
    // out_kind[2:0]
    output logic [abs_pkg::KindW-1:0]         m_axis_tuser
);
    import abs_pkg::*;

    localparam int              IdxW    = $clog2(PAYLOAD_BYTES + 1);
    localparam logic [IdxW-1:0] NBytes  = IdxW'(PAYLOAD_BYTES);
    localparam logic [IdxW-1:0] LastIdx = IdxW'(PAYLOAD_BYTES - 1);

    // Input fields
    logic [ByteW-1:0]   data_byte;
    logic [AckSeqW-1:0] ack_seq_field;
    logic [AckNumW-1:0] ack_num_field;
    logic [AckSumW-1:0] ack_check_field;

    assign data_byte       = s_axis_tdata[7:0];
    assign ack_seq_field   = s_axis_tdata[27:8];
    assign ack_num_field   = s_axis_tdata[47:28];
    assign ack_check_field = s_axis_tdata[69:48];

    // Registers
    state_t             state_reg, state_next;
    kind_t              kind_reg, kind_next;
    logic               seq_reg, seq_next;
    logic               awaiting_reg, awaiting_next;
    logic               dropping_reg, dropping_next;
    logic               zero_seen_reg, zero_seen_next;
    logic               num_match_reg, num_match_next;
    logic [IdxW-1:0]    idx_reg, idx_next;
    logic [IdxW-1:0]    cnt_reg, cnt_next;
    logic [ChkW-1:0]    sum_reg, sum_next;
    logic [ChkW-1:0]    chk_reg, chk_next;
    logic [AckSumW-1:0] rsum_reg, rsum_next;
    logic [ByteW-1:0]   store_reg [PAYLOAD_BYTES];
    logic [ByteW-1:0]   store_next [PAYLOAD_BYTES];

    // Decode
    logic               in_fire, out_fire;
    logic               is_msg, is_ack, is_tmo;
    logic               drop_now, room;
    logic [ByteW-1:0]   stored_byte;
    logic               msg_store, msg_end, drop_end, ack_end, replay;
    logic               send_done, last_slot;
    logic [ChkW-1:0]    sum_upd;
    logic [IdxW-1:0]    idx_after;
    logic [AckSumW-1:0] rsum_upd;
    logic               shift_en;
    logic [ByteW-1:0]   shift_in;
    ack_chk_status_t    chk_status;

    assign in_fire     = s_axis_tvalid && s_axis_tready;
    assign out_fire    = m_axis_tvalid && m_axis_tready;
    assign is_msg      = in_fire && (s_axis_tuser == REQ_MSG);
    assign is_ack      = in_fire && (s_axis_tuser == REQ_ACK);
    assign is_tmo      = in_fire && (s_axis_tuser == REQ_TIMEOUT);
    assign drop_now    = dropping_reg
                       | ((idx_reg == '0) && !zero_seen_reg && awaiting_reg);
    assign room        = idx_reg < NBytes;
    assign stored_byte = zero_seen_reg ? '0 : data_byte;
    assign msg_store   = is_msg && !drop_now && room;
    assign msg_end     = is_msg && !drop_now && s_axis_tlast;
    assign drop_end    = is_msg && drop_now && s_axis_tlast;
    assign ack_end     = is_ack && s_axis_tlast;
    assign replay      = is_tmo && awaiting_reg;
    assign last_slot   = (cnt_reg == LastIdx);
    assign send_done   = (state_reg == ST_SEND) && out_fire && last_slot;
    assign sum_upd     = msg_store ? (sum_reg + ChkW'(stored_byte)) : sum_reg;
    assign idx_after   = room ? (idx_reg + IdxW'(1)) : idx_reg;
    assign rsum_upd    = rsum_reg + AckSumW'(data_byte);

    // Bit-serial ack check
    abs_ack_chk u_ack_chk (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (ack_end),
        .ack_seq   (ack_seq_field),
        .ack_num   (ack_num_field),
        .ack_sum   (rsum_upd),
        .ack_check (ack_check_field),
        .status    (chk_status)
    );

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (msg_end)
                begin
                    state_next = (idx_after == NBytes) ? ST_SEND : ST_PAD;
                end
                else if (replay)
                begin
                    state_next = ST_SEND;
                end
                else if (drop_end)
                begin
                    state_next = ST_REPORT;
                end
                else if (ack_end)
                begin
                    state_next = ST_CHECK;
                end
            end
            ST_PAD:
            begin
                if (cnt_reg == IdxW'(1))
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (send_done)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_CHECK:
            begin
                if (chk_status.done)
                begin
                    state_next = ST_REPORT;
                end
            end
            ST_REPORT:
            begin
                if (out_fire)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Outputs
    always_comb
    begin
        logic is_send;
        logic tstart;
        logic tstop;
        is_send       = (state_reg == ST_SEND);
        tstart        = is_send && last_slot;
        tstop         = (state_reg == ST_REPORT) && (kind_reg == KIND_ACK_OK);
        s_axis_tready = (state_reg == ST_IDLE);
        m_axis_tvalid = is_send || (state_reg == ST_REPORT);
        m_axis_tlast  = (state_reg == ST_REPORT) || tstart;
        m_axis_tuser  = is_send ? KIND_PKT : kind_reg;
        m_axis_tdata  = {tstop, tstart,
                         is_send ? store_reg[0] : {ByteW{1'b0}},
                         is_send ? chk_reg : {ChkW{1'b0}},
                         is_send && seq_reg};
    end

    // Datapath and protocol state
    always_comb
    begin
        kind_next      = kind_reg;
        seq_next       = seq_reg;
        awaiting_next  = awaiting_reg;
        dropping_next  = dropping_reg;
        zero_seen_next = zero_seen_reg;
        num_match_next = num_match_reg;
        idx_next       = idx_reg;
        cnt_next       = cnt_reg;
        sum_next       = sum_reg;
        chk_next       = chk_reg;
        rsum_next      = rsum_reg;
        shift_en       = 1'b0;
        shift_in       = '0;

        // Message bytes: store, or discard while dropping
        if (is_msg)
        begin
            if (drop_now)
            begin
                dropping_next = !s_axis_tlast;
                if (s_axis_tlast)
                begin
                    idx_next       = '0;
                    zero_seen_next = 1'b0;
                    kind_next      = KIND_DROP;
                end
            end
            else
            begin
                if (msg_store)
                begin
                    shift_en = 1'b1;
                    shift_in = stored_byte;
                end
                idx_next       = idx_after;
                sum_next       = sum_upd;
                zero_seen_next = zero_seen_reg | (data_byte == '0);
                if (s_axis_tlast)
                begin
                    chk_next       = sum_upd + ChkW'(seq_reg);
                    sum_next       = '0;
                    idx_next       = '0;
                    zero_seen_next = 1'b0;
                    awaiting_next  = 1'b1;
                    cnt_next       = NBytes - idx_after;
                end
            end
        end

        // Ack bytes: accumulate, hand off to the checker at the end
        if (is_ack)
        begin
            rsum_next = s_axis_tlast ? '0 : rsum_upd;
            if (s_axis_tlast)
            begin
                num_match_next = (ack_num_field == AckNumW'(seq_reg));
            end
        end

        // A timeout while an ack is outstanding replays the stored packet
        if (replay)
        begin
            cnt_next = '0;
        end

        // Fill unwritten slots with zero
        if (state_reg == ST_PAD)
        begin
            shift_en = 1'b1;
            shift_in = '0;
            cnt_next = cnt_reg - IdxW'(1);
        end

        // Send: rotate the store once per transaction
        if ((state_reg == ST_SEND) && out_fire)
        begin
            shift_en = 1'b1;
            shift_in = store_reg[0];
            cnt_next = last_slot ? '0 : (cnt_reg + IdxW'(1));
        end

        // Act on the ack verdict
        if ((state_reg == ST_CHECK) && chk_status.done)
        begin
            if (chk_status.corrupt)
            begin
                kind_next = KIND_CORRUPT;
            end
            else if (awaiting_reg && num_match_reg)
            begin
                kind_next     = KIND_ACK_OK;
                seq_next      = !seq_reg;
                awaiting_next = 1'b0;
            end
            else
            begin
                kind_next = KIND_DUP;
            end
        end

        // Packet store shift line, head at slot zero
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            store_next[i] = store_reg[i];
        end
        if (shift_en)
        begin
            for (int i = 0; i < PAYLOAD_BYTES - 1; i++)
            begin
                store_next[i] = store_reg[i + 1];
            end
            store_next[PAYLOAD_BYTES - 1] = shift_in;
        end
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            kind_reg      <= KIND_PKT;
            seq_reg       <= 1'b0;
            awaiting_reg  <= 1'b0;
            dropping_reg  <= 1'b0;
            zero_seen_reg <= 1'b0;
            num_match_reg <= 1'b0;
            idx_reg       <= '0;
            cnt_reg       <= '0;
            sum_reg       <= '0;
            chk_reg       <= '0;
            rsum_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            kind_reg      <= kind_next;
            seq_reg       <= seq_next;
            awaiting_reg  <= awaiting_next;
            dropping_reg  <= dropping_next;
            zero_seen_reg <= zero_seen_next;
            num_match_reg <= num_match_next;
            idx_reg       <= idx_next;
            cnt_reg       <= cnt_next;
            sum_reg       <= sum_next;
            chk_reg       <= chk_next;
            rsum_reg      <= rsum_next;
        end
    end

    // Packet bytes
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < PAYLOAD_BYTES; i++)
        begin
            store_reg[i] <= store_next[i];
        end
    end

    // A packet is only sent while an ack is outstanding
    a_send_awaits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SEND) |-> awaiting_reg)
        else $error("packet sent with no ack outstanding");

    // The ack wait ends only through an accepted ack report
    a_ack_clears: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(awaiting_reg) |-> (state_reg == ST_REPORT) && (kind_reg == KIND_ACK_OK))
        else $error("ack wait cleared without an accepted ack");

    // Zero fill always has slots left to fill
    a_pad_count: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_PAD) |-> (cnt_reg != '0))
        else $error("zero fill entered with nothing to fill");

    // Checker finishes only while the sequencer waits for it
    a_chk_done: assert property (@(posedge clk) disable iff (!rst_n)
        chk_status.done |-> (state_reg == ST_CHECK))
        else $error("ack check finished outside the check state");

endmodule
